@@ rtl/micu_pkg.sv @@
package micu_pkg;

    // Payload field widths
    localparam int MASK_W  = 25;
    localparam int COUNT_W = 14;
    localparam int VCOUNT_W = 5;

    localparam logic [COUNT_W-1:0]  COUNT_MAX          = '1;
    localparam logic [VCOUNT_W-1:0] VERTEX_COUNT_RESET = 5'd25;

    // APB register port
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_WALK,
        ST_HOLD
    } t_state;

endpackage

@@ rtl/micu_if.sv @@
interface micu_mask_if;
    logic                        valid;
    logic                        ready;
    logic [micu_pkg::MASK_W-1:0] neighbor_mask;

    modport source (output valid, output neighbor_mask, input ready);
    modport sink   (input valid, input neighbor_mask, output ready);
endinterface

interface micu_count_if;
    logic                         valid;
    logic                         ready;
    logic [micu_pkg::COUNT_W-1:0] maximal_set_count;

    modport source (output valid, output maximal_set_count, input ready);
    modport sink   (input valid, input maximal_set_count, output ready);
endinterface

@@ rtl/maximal_independent_set_counter_unit.sv @@
// Operation: n mask beats (n = vertex count in use), then a walk
//   over subsets 1 to 2^n - 1; the last walk cycle loads the output register, so the
//   count is valid right after it (later only while an earlier count is held).
// Throughput: one graph per load plus walk; the walk is set by the single
//   shared row-check unit, which tests one vertex of one subset per cycle.
// Reset: synchronous, active low; clears control state, vertex_count to 25.
//   The adjacency store is not cleared; every row used is written by the load.
module maximal_independent_set_counter_unit #(
    parameter int MAX_VERTICES = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [micu_pkg::APB_AW-1:0]   paddr,
    input  logic [micu_pkg::APB_DW-1:0]   pwdata,
    output logic [micu_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    micu_mask_if.sink                     i_mask,
    micu_count_if.source                  o_count
);
    import micu_pkg::*;

    // Vertex index width and width of a vertex count (up to MAX_VERTICES).
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW = VCOUNT_W + 1;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [VCOUNT_W-1:0]  r_vertex_count;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_cfg_write;

    assign pready      = 1'b1;
    assign w_reg_idx   = paddr[APB_AW-1:2];
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VERTEX_COUNT_RESET;
        end else if (w_cfg_write && (w_reg_idx == REG_VERTEX_COUNT)) begin
            r_vertex_count <= pwdata[VCOUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg_idx == REG_VERTEX_COUNT) begin
            prdata = {{(APB_DW-VCOUNT_W){1'b0}}, r_vertex_count};
        end
    end

    // ------------------------------------------------------------------
    // Vertex count in use: zero acts as one, large values clamp to the
    // built maximum.
    // ------------------------------------------------------------------
    logic [NW-1:0]           w_n_used;
    logic [VW-1:0]           w_last_idx;
    logic [MAX_VERTICES-1:0] w_all;

    always_comb begin
        if (r_vertex_count == '0) begin
            w_n_used = NW'(1);
        end else if ({1'b0, r_vertex_count} > NW'(MAX_VERTICES)) begin
            w_n_used = NW'(MAX_VERTICES);
        end else begin
            w_n_used = {1'b0, r_vertex_count};
        end
        w_last_idx = VW'(w_n_used - NW'(1));
        for (int k = 0; k < MAX_VERTICES; k++) begin
            w_all[k] = (NW'(k) < w_n_used);
        end
    end

    // ------------------------------------------------------------------
    // Adjacency store: one row per vertex, written during the load.
    // Bits above the built maximum are dropped here.
    // ------------------------------------------------------------------
    logic [MAX_VERTICES-1:0] r_store [MAX_VERTICES];
    logic [31:0]             w_mask_wide;
    logic [VCOUNT_W-1:0]     r_load_index;
    logic                    w_in_beat;

    assign w_mask_wide = {{(32-MASK_W){1'b0}}, i_mask.neighbor_mask};
    assign w_in_beat   = i_mask.valid && i_mask.ready;

    always_ff @(posedge i_clk) begin
        if (w_in_beat && ({1'b0, r_load_index} < NW'(MAX_VERTICES))) begin
            r_store[r_load_index[VW-1:0]] <= w_mask_wide[MAX_VERTICES-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Walk: the cursor steps through subsets 1 .. all-ones. For each
    // subset the shared check unit visits one vertex per cycle:
    //   member     -> its row must miss the subset (independent)
    //   non-member -> its row must hit the subset (not addable)
    // Drop the subset on the first failing vertex; count it when the last
    // vertex passes.
    // ------------------------------------------------------------------
    t_state                  r_state, n_state;
    logic [MAX_VERTICES-1:0] r_cursor, n_cursor;
    logic [VW-1:0]           r_vertex, n_vertex;
    logic [COUNT_W-1:0]      r_count, n_count;
    logic [MAX_VERTICES-1:0] r_all, n_all;
    logic [VW-1:0]           r_last_vertex, n_last_vertex;
    logic [VCOUNT_W-1:0]     n_load_index;
    logic                    r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]      r_out_count, n_out_count;

    logic [MAX_VERTICES-1:0] w_row;
    logic                    w_hit;
    logic                    w_fail;
    logic                    w_last_vertex;
    logic                    w_last_subset;
    logic [COUNT_W-1:0]      w_count_inc;
    logic                    w_out_free;

    assign w_row         = r_store[r_vertex];
    assign w_hit         = |(w_row & r_cursor);
    assign w_fail        = r_cursor[r_vertex] ? w_hit : !w_hit;
    assign w_last_vertex = (r_vertex == r_last_vertex);
    assign w_last_subset = (r_cursor == r_all);
    assign w_count_inc   = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_W'(1);
    assign w_out_free    = !r_out_valid || o_count.ready;

    always_comb begin
        n_state       = r_state;
        n_cursor      = r_cursor;
        n_vertex      = r_vertex;
        n_count       = r_count;
        n_all         = r_all;
        n_last_vertex = r_last_vertex;
        n_load_index  = r_load_index;
        n_out_valid   = r_out_valid;
        n_out_count   = r_out_count;

        // Drop the result once the consumer takes it.
        if (r_out_valid && o_count.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_LOAD: begin
                if (w_in_beat) begin
                    if (({1'b0, r_load_index} + NW'(1)) < w_n_used) begin
                        n_load_index = r_load_index + VCOUNT_W'(1);
                    end else begin
                        // Last row in: start the walk at subset {0}.
                        n_load_index  = '0;
                        n_cursor      = MAX_VERTICES'(1);
                        n_vertex      = '0;
                        n_count       = '0;
                        n_all         = w_all;
                        n_last_vertex = w_last_idx;
                        n_state       = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (!w_fail && w_last_vertex) begin
                    n_count = w_count_inc;
                end
                if (w_fail || w_last_vertex) begin
                    n_vertex = '0;
                    if (w_last_subset) begin
                        n_cursor = '0;
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_out_count = n_count;
                            n_state     = ST_LOAD;
                        end else begin
                            n_state = ST_HOLD;
                        end
                    end else begin
                        n_cursor = r_cursor + MAX_VERTICES'(1);
                    end
                end else begin
                    n_vertex = r_vertex + VW'(1);
                end
            end
            ST_HOLD: begin
                // Hold the final count until the output register frees up.
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_count;
                    n_state     = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_cursor     <= '0;
            r_vertex     <= '0;
            r_count      <= '0;
            r_load_index <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cursor     <= n_cursor;
            r_vertex     <= n_vertex;
            r_count      <= n_count;
            r_load_index <= n_load_index;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_all         <= n_all;
        r_last_vertex <= n_last_vertex;
        r_out_count   <= n_out_count;
    end

    assign i_mask.ready              = (r_state == ST_LOAD);
    assign o_count.valid             = r_out_valid;
    assign o_count.maximal_set_count = r_out_count;

endmodule

@@ rtl/micu_checker.sv @@
module micu_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [micu_pkg::COUNT_W-1:0] i_out_count
);
    // Come out of reset ready for masks with no result pending.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_in_ready && !i_out_valid))
        else $error("block not idle after reset");

    // A result only appears after a walk, during which masks are refused.
    a_result_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result raised without a walk");

    // A mask beat never raises the result in the very next cycle.
    a_no_result_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result raised right after a mask beat");

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_count))
        else $error("result payload changed while stalled");

endmodule

bind maximal_independent_set_counter_unit micu_checker u_micu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_mask.valid),
    .i_in_ready  (i_mask.ready),
    .i_out_valid (o_count.valid),
    .i_out_ready (o_count.ready),
    .i_out_count (o_count.maximal_set_count)
);
